@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, cond, expr)
`define ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

@@ design/bptc_pkg.sv @@
// ----------------------------------------------------------------------------
// bptc_pkg
// shared types and constants of the barometer compensation pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package bptc_pkg;

  localparam int ADC_W      = 20;
  localparam int TFINE_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_NUM_W  = 64;
  localparam int DIV_DEN_W  = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_TEMP_A         = 3'd0,
    REG_CAL_TEMP_B_PRESS_A = 3'd1,
    REG_CAL_PRESS_B        = 3'd2,
    REG_CAL_PRESS_C        = 3'd3,
    REG_CAL_PRESS_D        = 3'd4,
    REG_CAL_PRESS_E        = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [ADC_W-1:0] adc_temp;
    logic [ADC_W-1:0] adc_press;
  } in_t;

  typedef struct packed {
    logic signed [31:0] fine_temp;
    logic signed [15:0] temp_centi;
    logic        [31:0] press_q24_8;
    logic               press_valid;
  } out_t;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } cal_t;

  typedef struct packed {
    logic signed [TFINE_W-1:0] tfine;
    logic signed [15:0]        tc;
  } temp_res_t;

  // travels alongside the division
  typedef struct packed {
    temp_res_t temp;
    logic      den_zero;
    logic      q_neg;
  } side_t;

endpackage

`default_nettype wire

@@ design/baro_temp_pressure_compensation_unit.sv @@
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_unit
// integer barometer compensation: fine temperature, centidegrees, Q24.8 Pa
// ----------------------------------------------------------------------------
// One word is taken on every clock edge where start is high and busy is low;
// busy is only raised during reset. Each word's result shows on result with
// done high for one cycle, in the order taken. The pressure division is a
// 64-stage divider retiring one quotient bit per stage, fed by 12 stages of
// temperature and pressure arithmetic and followed by 6 stages of correction
// and saturation. Calibration must be written through cfg_we/cfg_index/
// cfg_data only while no word is in flight; the block itself does not
// enforce this. A zero pressure divisor gives pressure 0 with press_valid
// low.
`default_nettype none

`include "assert_macros.svh"

module baro_temp_pressure_compensation_unit
  import bptc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_t                   sample,
  output logic                       done,
  output out_t                       result,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CFG_DATA_W-1:0] cal_temp_a;
  logic [CFG_DATA_W-1:0] cal_temp_b_press_a;
  logic [CFG_DATA_W-1:0] cal_press_b;
  logic [CFG_DATA_W-1:0] cal_press_c;
  logic [CFG_DATA_W-1:0] cal_press_d;
  logic [CFG_DATA_W-1:0] cal_press_e;
  cal_t                  cal;

  logic                  temp_valid;
  temp_res_t             temp;
  logic [ADC_W-1:0]      temp_press;
  logic                  pre_valid;
  logic [DIV_NUM_W-1:0]  pre_nm;
  logic [DIV_DEN_W-1:0]  pre_dm;
  side_t                 pre_side;
  logic                  div_valid;
  logic [DIV_NUM_W-1:0]  div_q;
  side_t                 div_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp_a         <= '0;
      cal_temp_b_press_a <= '0;
      cal_press_b        <= '0;
      cal_press_c        <= '0;
      cal_press_d        <= '0;
      cal_press_e        <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CAL_TEMP_A:         cal_temp_a         <= cfg_data;
        REG_CAL_TEMP_B_PRESS_A: cal_temp_b_press_a <= cfg_data;
        REG_CAL_PRESS_B:        cal_press_b        <= cfg_data;
        REG_CAL_PRESS_C:        cal_press_c        <= cfg_data;
        REG_CAL_PRESS_D:        cal_press_d        <= cfg_data;
        REG_CAL_PRESS_E:        cal_press_e        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cal.t1 = cal_temp_a[15:0];
    cal.t2 = cal_temp_a[31:16];
    cal.t3 = cal_temp_b_press_a[15:0];
    cal.p1 = cal_temp_b_press_a[31:16];
    cal.p2 = cal_press_b[15:0];
    cal.p3 = cal_press_b[31:16];
    cal.p4 = cal_press_c[15:0];
    cal.p5 = cal_press_c[31:16];
    cal.p6 = cal_press_d[15:0];
    cal.p7 = cal_press_d[31:16];
    cal.p8 = cal_press_e[15:0];
    cal.p9 = cal_press_e[31:16];
  end

  assign busy = rst;

  bptc_temp u_temp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .sample    (sample),
    .cal       (cal),
    .out_valid (temp_valid),
    .temp      (temp),
    .adc_press (temp_press)
  );

  bptc_press_pre u_pre (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (temp_valid),
    .temp      (temp),
    .adc_press (temp_press),
    .cal       (cal),
    .out_valid (pre_valid),
    .nm        (pre_nm),
    .dm        (pre_dm),
    .side      (pre_side)
  );

  bptc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pre_valid),
    .nm        (pre_nm),
    .dm        (pre_dm),
    .side_in   (pre_side),
    .out_valid (div_valid),
    .q         (div_q),
    .side_out  (div_side)
  );

  bptc_press_post u_post (
    .clk      (clk),
    .rst      (rst),
    .in_valid (div_valid),
    .q        (div_q),
    .side     (div_side),
    .cal      (cal),
    .done     (done),
    .result   (result)
  );

  // a flagged pressure is always forced to zero
  `ASSERT_IMPLY(a_invalid_zero, clk, rst, done && !result.press_valid, result.press_q24_8 == 32'd0)
  // non-negative fine temperature never rounds to a negative centidegree value
  `ASSERT_IMPLY(a_temp_sign, clk, rst, done && !result.fine_temp[31], !result.temp_centi[15])
  // reset empties the pipeline
  `ASSERT_NEXT(a_reset_quiet, clk, 1'b0, rst, !done)

endmodule

`default_nettype wire

@@ design/bptc_temp.sv @@
// ----------------------------------------------------------------------------
// bptc_temp
// five-stage temperature compensation: fine temperature and centidegrees
// ----------------------------------------------------------------------------
`default_nettype none

module bptc_temp
  import bptc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire in_t              sample,
  input  wire cal_t             cal,
  output logic                  out_valid,
  output temp_res_t             temp,
  output logic [ADC_W-1:0]      adc_press
);

  logic                     v1, v2, v3, v4, v5;
  logic [ADC_W-1:0]         pr1, pr2, pr3, pr4, pr5;
  logic signed [17:0]       x1;
  logic signed [16:0]       d1;
  logic signed [33:0]       m2;
  logic [31:0]              dd2;
  logic signed [22:0]       at3;
  logic signed [36:0]       bm3;
  logic signed [TFINE_W-1:0] tfine4;
  temp_res_t                res5;

  logic signed [17:0]       x_c;
  logic signed [16:0]       d_c;
  logic signed [33:0]       m_c;
  logic signed [33:0]       sq_c;
  logic signed [36:0]       bm_c;
  logic signed [TFINE_W-1:0] tf_c;
  logic signed [26:0]       t5_c;
  logic signed [18:0]       sh_c;
  logic signed [15:0]       tc_c;

  always_comb begin
    x_c  = $signed({1'b0, sample.adc_temp[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
    d_c  = $signed({1'b0, sample.adc_temp[19:4]}) - $signed({1'b0, cal.t1});
    m_c  = x1 * cal.t2;
    sq_c = d1 * d1;
    bm_c = $signed({1'b0, dd2[31:12]}) * cal.t3;
    tf_c = TFINE_W'(at3) + TFINE_W'($signed(bm3[36:14]));
    t5_c = 27'(tfine4) * 27'sd5 + 27'sd128;
    sh_c = t5_c[26:8];
    // saturate to 16 bits
    if (sh_c[18:15] == {4{sh_c[15]}}) begin
      tc_c = sh_c[15:0];
    end else if (sh_c[18]) begin
      tc_c = 16'sh8000;
    end else begin
      tc_c = 16'sh7fff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    x1        <= x_c;
    d1        <= d_c;
    pr1       <= sample.adc_press;
    m2        <= m_c;
    dd2       <= sq_c[31:0];
    pr2       <= pr1;
    at3       <= m2[33:11];
    bm3       <= bm_c;
    pr3       <= pr2;
    tfine4    <= tf_c;
    pr4       <= pr3;
    res5.tfine <= tfine4;
    res5.tc   <= tc_c;
    pr5       <= pr4;
  end

  assign out_valid = v5;
  assign temp      = res5;
  assign adc_press = pr5;

endmodule

`default_nettype wire

@@ design/bptc_press_pre.sv @@
// ----------------------------------------------------------------------------
// bptc_press_pre
// seven-stage pressure front end: builds the signed dividend and divisor
// ----------------------------------------------------------------------------
`default_nettype none

module bptc_press_pre
  import bptc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire temp_res_t             temp,
  input  wire logic [ADC_W-1:0]      adc_press,
  input  wire cal_t                  cal,
  output logic                       out_valid,
  output logic [DIV_NUM_W-1:0]       nm,
  output logic [DIV_DEN_W-1:0]       dm,
  output side_t                      side
);

  logic [6:0]          v;
  temp_res_t           t6, t7, t8, t9, t10, t11;
  logic [ADC_W-1:0]    pr6, pr7, pr8, pr9;

  logic signed [TFINE_W-1:0] ap6;
  logic signed [47:0]  asq7;
  logic signed [39:0]  ap5_7, ap2_7, ap5_8, ap2_8;
  logic signed [63:0]  b6_8, a3_8;
  logic signed [63:0]  bsum9;
  logic signed [55:0]  asum9;
  logic signed [63:0]  prod10;
  logic [63:0]         diff10;
  logic signed [DIV_DEN_W-1:0] den11;
  logic [63:0]         num11;

  logic signed [63:0]  bsum_c, asum_c;
  logic signed [72:0]  prod_c;
  logic [20:0]         p_c;
  logic [63:0]         diff_c;

  always_comb begin
    bsum_c = b6_8 + (64'(ap5_8) <<< 17) + (64'(cal.p4) <<< 35);
    asum_c = (a3_8 >>> 8) + (64'(ap2_8) <<< 12) + (64'sd1 <<< 47);
    prod_c = asum9 * $signed({1'b0, cal.p1});
    p_c    = 21'd1048576 - {1'b0, pr9};
    diff_c = (64'(p_c) << 31) - 64'(bsum9);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    ap6    <= temp.tfine - 24'sd128000;
    t6     <= temp;
    pr6    <= adc_press;

    asq7   <= ap6 * ap6;
    ap5_7  <= ap6 * cal.p5;
    ap2_7  <= ap6 * cal.p2;
    t7     <= t6;
    pr7    <= pr6;

    b6_8   <= asq7 * cal.p6;
    a3_8   <= asq7 * cal.p3;
    ap5_8  <= ap5_7;
    ap2_8  <= ap2_7;
    t8     <= t7;
    pr8    <= pr7;

    bsum9  <= bsum_c;
    asum9  <= asum_c[55:0];
    t9     <= t8;
    pr9    <= pr8;

    prod10 <= prod_c[63:0];
    diff10 <= diff_c;
    t10    <= t9;

    den11  <= prod10[63:33];
    num11  <= diff10 * 64'd3125;
    t11    <= t10;

    // magnitudes for the unsigned divider, quotient sign kept aside
    nm     <= num11[63] ? (64'd0 - num11) : num11;
    dm     <= den11[DIV_DEN_W-1] ? (DIV_DEN_W'(0) - den11) : den11;
    side.temp     <= t11;
    side.den_zero <= (den11 == '0);
    side.q_neg    <= num11[63] ^ den11[DIV_DEN_W-1];
  end

  assign out_valid = v[6];

endmodule

`default_nettype wire

@@ design/bptc_div.sv @@
// ----------------------------------------------------------------------------
// bptc_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module bptc_div
  import bptc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [DIV_NUM_W-1:0]  nm,
  input  wire logic [DIV_DEN_W-1:0]  dm,
  input  wire side_t                 side_in,
  output logic                       out_valid,
  output logic [DIV_NUM_W-1:0]       q,
  output side_t                      side_out
);

  // stage registers, index DIV_NUM_W is the final register
  logic                 vs   [1:DIV_NUM_W];
  logic [DIV_NUM_W-1:0] work [1:DIV_NUM_W];
  logic [DIV_DEN_W-1:0] rem  [1:DIV_NUM_W];
  logic [DIV_DEN_W-1:0] dmr  [1:DIV_NUM_W];
  side_t                sd   [1:DIV_NUM_W];

  // stage inputs, index 0 is the divider input
  logic                 vs_in   [0:DIV_NUM_W-1];
  logic [DIV_NUM_W-1:0] work_in [0:DIV_NUM_W-1];
  logic [DIV_DEN_W-1:0] rem_in  [0:DIV_NUM_W-1];
  logic [DIV_DEN_W-1:0] dmr_in  [0:DIV_NUM_W-1];
  side_t                sd_in   [0:DIV_NUM_W-1];

  logic [DIV_DEN_W-1:0] rem_next  [0:DIV_NUM_W-1];
  logic [DIV_NUM_W-1:0] work_next [0:DIV_NUM_W-1];

  always_comb begin
    vs_in[0]   = in_valid;
    work_in[0] = nm;
    rem_in[0]  = '0;
    dmr_in[0]  = dm;
    sd_in[0]   = side_in;
    for (int i = 1; i < DIV_NUM_W; i++) begin
      vs_in[i]   = vs[i];
      work_in[i] = work[i];
      rem_in[i]  = rem[i];
      dmr_in[i]  = dmr[i];
      sd_in[i]   = sd[i];
    end
  end

  always_comb begin
    logic [DIV_DEN_W:0] trial;
    logic [DIV_DEN_W:0] sub;
    logic               ge;
    for (int i = 0; i < DIV_NUM_W; i++) begin
      trial = {rem_in[i], work_in[i][DIV_NUM_W-1]};
      sub   = trial - {1'b0, dmr_in[i]};
      ge    = (trial >= {1'b0, dmr_in[i]});
      rem_next[i]  = ge ? sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      // numerator bits shift out the top, quotient bits shift in below
      work_next[i] = {work_in[i][DIV_NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIV_NUM_W; i++) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else begin
        vs[i+1] <= vs_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIV_NUM_W; i++) begin
      rem[i+1]  <= rem_next[i];
      work[i+1] <= work_next[i];
      dmr[i+1]  <= dmr_in[i];
      sd[i+1]   <= sd_in[i];
    end
  end

  assign out_valid = vs[DIV_NUM_W];
  assign q         = work[DIV_NUM_W];
  assign side_out  = sd[DIV_NUM_W];

endmodule

`default_nettype wire

@@ design/bptc_press_post.sv @@
// ----------------------------------------------------------------------------
// bptc_press_post
// six-stage pressure back end: quotient sign, correction terms, saturation
// ----------------------------------------------------------------------------
`default_nettype none

module bptc_press_post
  import bptc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [DIV_NUM_W-1:0]  q,
  input  wire side_t                 side,
  input  wire cal_t                  cal,
  output logic                       done,
  output out_t                       result
);

  logic [5:0]         v;
  side_t              s0, s1, s2, s3, s4;
  logic signed [63:0] p0, p1, p2, p3;
  logic [63:0]        mll1;
  logic [30:0]        mlh1;
  logic signed [63:0] pb1, pb2, pb3;
  logic [63:0]        sq2;
  logic signed [63:0] pa3;
  logic signed [63:0] sum4;

  logic signed [63:0] d_c;
  logic [63:0]        lh_c;
  logic signed [63:0] fin_c;
  logic [31:0]        pres_c;

  always_comb begin
    d_c   = p0 >>> 13;
    // low half of the square only needs the low cross product
    lh_c  = 64'(d_c[31:0]) * 64'(d_c[63:32]);
    fin_c = (sum4 >>> 8) + (64'(cal.p7) <<< 4);
    if (fin_c[63]) begin
      pres_c = '0;
    end else if (|fin_c[62:32]) begin
      pres_c = '1;
    end else begin
      pres_c = fin_c[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    p0   <= side.q_neg ? $signed(64'd0 - q) : $signed(q);
    s0   <= side;

    mll1 <= 64'(d_c[31:0]) * 64'(d_c[31:0]);
    mlh1 <= lh_c[30:0];
    pb1  <= p0 * 64'(cal.p8);
    p1   <= p0;
    s1   <= s0;

    sq2  <= mll1 + {mlh1, 33'd0};
    pb2  <= pb1;
    p2   <= p1;
    s2   <= s1;

    pa3  <= $signed(sq2) * 64'(cal.p9);
    pb3  <= pb2;
    p3   <= p2;
    s3   <= s2;

    sum4 <= p3 + (pa3 >>> 25) + (pb3 >>> 19);
    s4   <= s3;

    result.fine_temp   <= 32'(s4.temp.tfine);
    result.temp_centi  <= s4.temp.tc;
    result.press_q24_8 <= s4.den_zero ? 32'd0 : pres_c;
    result.press_valid <= !s4.den_zero;
  end

  assign done = v[5];

endmodule

`default_nettype wire

@@ tb/tb_baro_temp_pressure_compensation_unit.sv @@
// ----------------------------------------------------------------------------
// tb_baro_temp_pressure_compensation_unit
// self-checking bench for the barometer compensation pipeline: calibration
// sets, directed and random raw samples, every result checked in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb_baro_temp_pressure_compensation_unit;
  import bptc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int PIPE_WAIT    = 120;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  class comp_scoreboard;
    logic [31:0] cal_word[6];
    out_t        pending[$];
    int          errors;
    int          checked;
    int          invalid_seen;

    function new();
      foreach (cal_word[i]) cal_word[i] = '0;
      errors = 0;
      checked = 0;
      invalid_seen = 0;
    endfunction

    function void write_cal(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      if (idx < 6) cal_word[idx] = data;
    endfunction

    function bit [63:0] sx16(bit [15:0] v);
      return {{48{v[15]}}, v};
    endfunction

    function bit [63:0] asr(bit [63:0] x, int n);
      return $signed(x) >>> n;
    endfunction

    // all model arithmetic wraps at 64 bits
    function out_t compensate(in_t s);
      bit [63:0] at, ap, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      bit [63:0] a, b, d, tf, num, p, nm, dm, q;
      bit signed [63:0] ts, ps;
      out_t r;
      at = {44'd0, s.adc_temp};
      ap = {44'd0, s.adc_press};
      t1 = {48'd0, cal_word[0][15:0]};
      t2 = sx16(cal_word[0][31:16]);
      t3 = sx16(cal_word[1][15:0]);
      p1 = {48'd0, cal_word[1][31:16]};
      p2 = sx16(cal_word[2][15:0]);
      p3 = sx16(cal_word[2][31:16]);
      p4 = sx16(cal_word[3][15:0]);
      p5 = sx16(cal_word[3][31:16]);
      p6 = sx16(cal_word[4][15:0]);
      p7 = sx16(cal_word[4][31:16]);
      p8 = sx16(cal_word[5][15:0]);
      p9 = sx16(cal_word[5][31:16]);

      a = asr(((at >> 3) - (t1 << 1)) * t2, 11);
      d = (at >> 4) - t1;
      b = asr(asr(d * d, 12) * t3, 14);
      tf = a + b;
      tf = {{32{tf[31]}}, tf[31:0]};
      ts = $signed(asr(tf * 64'd5 + 64'd128, 8));
      if (ts > 64'sd32767) ts = 64'sd32767;
      if (ts < -64'sd32768) ts = -64'sd32768;
      r.fine_temp  = tf[31:0];
      r.temp_centi = ts[15:0];

      a = tf - 64'd128000;
      b = a * a * p6;
      b = b + ((a * p5) << 17);
      b = b + (p4 << 35);
      a = asr(a * a * p3, 8) + ((a * p2) << 12);
      a = ((64'd1 << 47) + a) * p1;
      a = asr(a, 33);
      if (a == 64'd0) begin
        r.press_q24_8 = '0;
        r.press_valid = 1'b0;
      end else begin
        p = 64'd1048576 - ap;
        num = ((p << 31) - b) * 64'd3125;
        // truncating division on magnitudes
        nm = num[63] ? -num : num;
        dm = a[63] ? -a : a;
        q = nm / dm;
        p = (num[63] != a[63]) ? -q : q;
        d = asr(p, 13);
        a = asr(p9 * d * d, 25);
        b = asr(p8 * p, 19);
        p = asr(p + a + b, 8) + (p7 << 4);
        ps = $signed(p);
        if (ps < 0) r.press_q24_8 = '0;
        else if (ps > 64'sh00000000FFFFFFFF) r.press_q24_8 = 32'hFFFFFFFF;
        else r.press_q24_8 = p[31:0];
        r.press_valid = 1'b1;
      end
      return r;
    endfunction

    function void note_sample(in_t s);
      pending.push_back(compensate(s));
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (!exp_r.press_valid) invalid_seen++;
      if (got.fine_temp !== exp_r.fine_temp) begin
        $display("%0t: fine_temp exp %0d got %0d", $time, exp_r.fine_temp, got.fine_temp);
        errors++;
      end
      if (got.temp_centi !== exp_r.temp_centi) begin
        $display("%0t: temp_centi exp %0d got %0d", $time, exp_r.temp_centi,
                 got.temp_centi);
        errors++;
      end
      if (got.press_q24_8 !== exp_r.press_q24_8) begin
        $display("%0t: press_q24_8 exp %h got %h", $time, exp_r.press_q24_8,
                 got.press_q24_8);
        errors++;
      end
      if (got.press_valid !== exp_r.press_valid) begin
        $display("%0t: press_valid exp %b got %b", $time, exp_r.press_valid,
                 got.press_valid);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  in_t                   sample;
  logic                  done;
  out_t                  result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  comp_scoreboard sb;
  int cycles;
  int idle_pct;

  baro_temp_pressure_compensation_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample(sample),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && start && !busy) sb.note_sample(sample);
    if (!rst && done) sb.check_result(result);
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_cal(idx, data);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // word held on the port until taken; start is left high afterwards
  task automatic send_word(in_t s);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
    @(negedge clk);
    start  <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  task automatic load_cal(logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                          logic [31:0] c3, logic [31:0] c4, logic [31:0] c5);
    write_reg(REG_CAL_TEMP_A, c0);
    write_reg(REG_CAL_TEMP_B_PRESS_A, c1);
    write_reg(REG_CAL_PRESS_B, c2);
    write_reg(REG_CAL_PRESS_C, c3);
    write_reg(REG_CAL_PRESS_D, c4);
    write_reg(REG_CAL_PRESS_E, c5);
    end_writes();
  endtask

  function automatic logic [15:0] jitter(logic [15:0] v);
    return v + 16'($signed($urandom_range(64)) - 32);
  endfunction

  // typical part calibration with small random offsets
  task automatic load_typical();
    load_cal({jitter(16'd26435), jitter(16'd27504)},
             {jitter(16'd36477), jitter(-16'sd1000)},
             {jitter(16'd3024), jitter(-16'sd10685)},
             {jitter(16'd140), jitter(16'd2855)},
             {jitter(16'd15500), jitter(-16'sd7)},
             {jitter(16'd6000), jitter(-16'sd14600)});
  endtask

  function automatic in_t typical_sample();
    in_t s;
    s.adc_temp  = 20'd519888 + 20'($urandom_range(80000)) - 20'd40000;
    s.adc_press = 20'd415148 + 20'($urandom_range(160000)) - 20'd80000;
    return s;
  endfunction

  function automatic in_t any_sample();
    in_t s;
    s.adc_temp  = 20'($urandom);
    s.adc_press = 20'($urandom);
    return s;
  endfunction

  task automatic run_phase(int n, bit typical);
    in_t s;
    for (int i = 0; i < n; i++) begin
      s = (typical && $urandom_range(9) < 8) ? typical_sample() : any_sample();
      send_word(s);
      if (i == n / 2 && $urandom_range(1)) drain();
    end
    drain();
  endtask

  initial begin
    in_t s;
    sb = new();
    cycles = 0;
    idle_pct = 12;
    rst = 1'b1;
    start = 1'b0;
    sample = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset calibration: pressure divisor is zero
    s = '0; send_word(s);
    s = '1; send_word(s);
    s.adc_temp = '0; s.adc_press = '1; send_word(s);
    drain();

    load_cal({16'd26435, 16'd27504}, {16'd36477, -16'sd1000},
             {16'd3024, -16'sd10685}, {16'd140, 16'd2855},
             {16'd15500, -16'sd7}, {16'd6000, -16'sd14600});
    s.adc_temp = 20'd519888; s.adc_press = 20'd415148; send_word(s);
    s = '0; send_word(s);
    s = '1; send_word(s);
    s.adc_temp = '1; s.adc_press = '0; send_word(s);
    s.adc_temp = '0; s.adc_press = '1; send_word(s);
    s.adc_temp = 20'h55555; s.adc_press = 20'hAAAAA; send_word(s);
    s.adc_temp = 20'hAAAAA; s.adc_press = 20'h55555; send_word(s);
    drain();

    // spare index must not disturb the calibration
    write_reg(REG_SPARE, 32'hFFFFFFFF);
    end_writes();
    s.adc_temp = 20'd519888; s.adc_press = 20'd415148; send_word(s);
    drain();

    // extreme coefficients: saturation and wrapping
    load_cal('1, '1, '1, '1, '1, '1);
    s = '1; send_word(s);
    s = '0; send_word(s);
    drain();
    load_cal(32'h7FFF0000, 32'hFFFF8000, 32'h80007FFF, 32'h7FFF8000,
             32'h80007FFF, 32'h7FFF8000);
    s = '1; send_word(s);
    s = '0; send_word(s);
    s.adc_temp = '0; s.adc_press = '1; send_word(s);
    drain();
    load_cal(32'h8000FFFF, 32'h00017FFF, 32'h7FFF8000, 32'h80007FFF,
             32'h7FFF8000, 32'h80007FFF);
    s = '1; send_word(s);
    s = '0; send_word(s);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      idle_pct = (ph < 2) ? 12 : (ph < 4) ? 72 : 0;
      case (ph % 3)
        0: load_typical();
        1: load_cal($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: begin
          load_typical();
          // drop the pressure scale now and then to hit the zero divisor
          write_reg(REG_CAL_TEMP_B_PRESS_A, {16'd0, 16'($urandom)});
          end_writes();
        end
      endcase
      run_phase(95, ph % 3 != 1);
    end

    $display("checked %0d results (%0d with zero pressure divisor)", sb.checked,
             sb.invalid_seen);
    $display("calibration sets: reset, typical, extremes, random; %0d mismatches",
             sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+design
design/bptc_pkg.sv
design/bptc_temp.sv
design/bptc_press_pre.sv
design/bptc_div.sv
design/bptc_press_post.sv
design/baro_temp_pressure_compensation_unit.sv
tb/tb_baro_temp_pressure_compensation_unit.sv
